// File: hw/rtl/dsf_pkg.sv
package dsf_pkg;

   localparam int DSF_MID_DEPTH = 4;
   localparam int DSF_OUT_DEPTH = 4;

   localparam int SQRT_STEPS = 32;
   localparam int RATIO_BITS = 46;
   localparam int UNIT_BITS  = 31;

   localparam logic [RATIO_BITS-1:0] RATIO_MAX = '1;
   localparam logic [33:0]           FORCE_MAX = '1;
   localparam logic [30:0]           OUT_MAX   = '1;

   typedef struct packed {
      logic signed [31:0] delta_x;
      logic signed [31:0] delta_y;
      logic signed [31:0] delta_z;
      logic signed [31:0] rel_vel_x;
      logic signed [31:0] rel_vel_y;
      logic signed [31:0] rel_vel_z;
      logic [30:0]        rest_length;
      logic [16:0]        stiffness;
      logic [16:0]        damping;
      logic               end_a_dynamic;
      logic               end_b_dynamic;
   } req_type;

   typedef struct packed {
      logic signed [31:0] force_a_x;
      logic signed [31:0] force_a_y;
      logic signed [31:0] force_a_z;
      logic signed [31:0] force_b_x;
      logic signed [31:0] force_b_y;
      logic signed [31:0] force_b_z;
      logic               apply_a;
      logic               apply_b;
      logic               degenerate;
   } rsp_type;

   typedef struct packed {
      logic [2:0][31:0] d_mag;
      logic [2:0]       d_neg;
      logic [47:0]      dot_mag;
      logic             dot_neg;
      logic [30:0]      rest;
      logic [16:0]      k;
      logic [16:0]      c;
      logic             a_dyn;
      logic             b_dyn;
      logic             degen;
   } side_type;

   typedef struct packed {
      side_type    side;
      logic [63:0] sq_sum;
   } mid_type;

endpackage

// File: hw/rtl/damped_spring_force.sv
// Damped spring force for one mass-spring cloth link per transfer.
// The request side is a queue input: an item transfers on a rising edge with
// push high and full low. The response side is a queue output: the oldest
// result sits on rsp_data while empty is low and transfers on an edge with pop
// high. Every request yields exactly one response, in order.
// Throughput is one spring per cycle while full is low. The length comes from
// a 32-stage square root pipeline and the damping ratio and unit vector from
// a 46-stage divider pipeline, with a two-stage front end and four multiply
// and clamp stages.
// The front end fills a short queue that the back pipeline drains; the back
// pipeline fills the response queue. When the receiver stops popping, the
// response queue fills, the back pipeline holds, the middle queue fills and
// full rises. No result is lost or repeated across a stall.
// Synchronous reset empties both queues and clears every valid bit; full is
// low and empty is high in the cycle after reset.
module damped_spring_force
   import dsf_pkg::*;
#(
   parameter int MID_DEPTH = DSF_MID_DEPTH,
   parameter int OUT_DEPTH = DSF_OUT_DEPTH
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    push,
   input  req_type req_data,
   output logic    full,
   input  logic    pop,
   output rsp_type rsp_data,
   output logic    empty
);

   logic    front_valid;
   mid_type front_item;
   logic    mid_full, mid_empty, mid_pop;
   mid_type mid_head;
   logic    back_valid;
   rsp_type back_item;
   logic    out_full;

   dsf_front u_front (
      .clock     (clock),
      .reset     (reset),
      .in_push   (push),
      .in_item   (req_data),
      .in_full   (full),
      .out_valid (front_valid),
      .out_item  (front_item),
      .out_ready (!mid_full)
   );

   dsf_fifo #(
      .DEPTH (MID_DEPTH),
      .WIDTH ($bits(mid_type))
   ) u_mid_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (front_valid),
      .push_data (front_item),
      .full      (mid_full),
      .pop       (mid_pop),
      .pop_data  (mid_head),
      .empty     (mid_empty)
   );

   dsf_back u_back (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (!mid_empty),
      .in_item   (mid_head),
      .in_pop    (mid_pop),
      .out_valid (back_valid),
      .out_item  (back_item),
      .out_ready (!out_full)
   );

   dsf_fifo #(
      .DEPTH (OUT_DEPTH),
      .WIDTH ($bits(rsp_type))
   ) u_out_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (back_valid),
      .push_data (back_item),
      .full      (out_full),
      .pop       (pop),
      .pop_data  (rsp_data),
      .empty     (empty)
   );

   a_reset_empty: assert property (@(posedge clock) reset |=> empty)
      else $error("response queue not empty after reset");

   a_reset_not_full: assert property (@(posedge clock) reset |=> !full)
      else $error("request side full after reset");

   a_force_negated: assert property (@(posedge clock) disable iff (reset)
      !empty |-> (rsp_data.force_b_x == -rsp_data.force_a_x) &&
                 (rsp_data.force_b_y == -rsp_data.force_a_y) &&
                 (rsp_data.force_b_z == -rsp_data.force_a_z))
      else $error("force on end B is not the negation of force on end A");

   a_degenerate_idle: assert property (@(posedge clock) disable iff (reset)
      (!empty && rsp_data.degenerate) |->
         !rsp_data.apply_a && !rsp_data.apply_b &&
         (rsp_data.force_a_x == '0) && (rsp_data.force_a_y == '0) &&
         (rsp_data.force_a_z == '0))
      else $error("degenerate spring carries force");

endmodule

// File: hw/rtl/dsf_fifo.sv
module dsf_fifo #(
   parameter int DEPTH = 4,
   parameter int WIDTH = 8
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] push_data,
   output logic             full,
   input  logic             pop,
   output logic [WIDTH-1:0] pop_data,
   output logic             empty
);

   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [AW-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [AW-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0]    count_ff, count_in;
   logic             do_push, do_pop;

   assign full     = (count_ff == CW'(DEPTH));
   assign empty    = (count_ff == '0);
   assign do_push  = push && !full;
   assign do_pop   = pop && !empty;
   assign pop_data = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == AW'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == AW'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

// File: hw/rtl/dsf_front.sv
module dsf_front
   import dsf_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    in_push,
   input  req_type in_item,
   output logic    in_full,
   output logic    out_valid,
   output mid_type out_item,
   input  logic    out_ready
);

   typedef struct packed {
      side_type         side;
      logic [2:0][63:0] sq;
      logic [2:0][63:0] prod;
   } prod_type;

   logic        p1_valid_ff, p1_valid_in;
   prod_type    p1_ff, p1_in;
   logic        p2_valid_ff, p2_valid_in;
   mid_type     p2_ff, p2_in;
   logic        adv1, adv2;

   logic signed [63:0] dw [3];
   logic signed [63:0] vw [3];
   logic [63:0]        pmag [3];
   logic [49:0]        term [3];
   logic [49:0]        dot;

   assign adv2      = !p2_valid_ff || out_ready;
   assign adv1      = !p1_valid_ff || adv2;
   assign in_full   = !adv1;
   assign out_valid = p2_valid_ff;
   assign out_item  = p2_ff;

   always_comb begin
      dw[0] = 64'(in_item.delta_x);
      dw[1] = 64'(in_item.delta_y);
      dw[2] = 64'(in_item.delta_z);
      vw[0] = 64'(in_item.rel_vel_x);
      vw[1] = 64'(in_item.rel_vel_y);
      vw[2] = 64'(in_item.rel_vel_z);
      p1_in = '0;
      for (int i = 0; i < 3; i++) begin
         p1_in.sq[i]         = dw[i] * dw[i];
         p1_in.prod[i]       = vw[i] * dw[i];
         p1_in.side.d_neg[i] = dw[i][63];
         p1_in.side.d_mag[i] = dw[i][63] ? 32'(-dw[i]) : dw[i][31:0];
      end
      p1_in.side.rest  = in_item.rest_length;
      p1_in.side.k     = in_item.stiffness;
      p1_in.side.c     = in_item.damping;
      p1_in.side.a_dyn = in_item.end_a_dynamic;
      p1_in.side.b_dyn = in_item.end_b_dynamic;
      p1_valid_in      = adv1 ? in_push : p1_valid_ff;
   end

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         pmag[i] = p1_ff.prod[i][63] ? -p1_ff.prod[i] : p1_ff.prod[i];
         term[i] = p1_ff.prod[i][63] ? -{2'b00, pmag[i][63:16]} : {2'b00, pmag[i][63:16]};
      end
      dot                = term[0] + term[1] + term[2];
      p2_in.side         = p1_ff.side;
      p2_in.side.dot_neg = dot[49];
      p2_in.side.dot_mag = dot[49] ? 48'(-dot) : dot[47:0];
      p2_in.sq_sum       = p1_ff.sq[0] + p1_ff.sq[1] + p1_ff.sq[2];
      p2_in.side.degen   = (p2_in.sq_sum == '0);
      p2_valid_in        = adv2 ? p1_valid_ff : p2_valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         p1_valid_ff <= 1'b0;
         p2_valid_ff <= 1'b0;
      end else begin
         p1_valid_ff <= p1_valid_in;
         p2_valid_ff <= p2_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (adv1) begin
         p1_ff <= p1_in;
      end
      if (adv2) begin
         p2_ff <= p2_in;
      end
   end

endmodule

// File: hw/rtl/dsf_back.sv
module dsf_back
   import dsf_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    in_valid,
   input  mid_type in_item,
   output logic    in_pop,
   output logic    out_valid,
   output rsp_type out_item,
   input  logic    out_ready
);

   localparam int E_STAGE    = SQRT_STEPS;
   localparam int DV_FIRST   = E_STAGE + 1;
   localparam int M1_STAGE   = DV_FIRST + RATIO_BITS;
   localparam int OUT_STAGE  = M1_STAGE + 3;
   localparam int PIPE_DEPTH = OUT_STAGE + 1;

   typedef struct packed {
      side_type    side;
      logic [63:0] n;
      logic [34:0] rem;
      logic [31:0] root;
   } sq_type;

   typedef struct packed {
      logic [2:0]                 d_neg;
      logic                       dot_neg;
      logic [16:0]                k;
      logic [16:0]                c;
      logic                       a_dyn;
      logic                       b_dyn;
      logic                       degen;
      logic [31:0]                len;
      logic                       diff_neg;
      logic [32:0]                diff_mag;
      logic                       sat;
      logic [31:0]                r_rem;
      logic [RATIO_BITS-1:0]      r_low;
      logic [RATIO_BITS-1:0]      r_q;
      logic [2:0][31:0]           u_rem;
      logic [2:0][UNIT_BITS-1:0]  u_low;
      logic [2:0][UNIT_BITS-1:0]  u_q;
   } dv_type;

   typedef struct packed {
      logic [2:0]                d_neg;
      logic                      dot_neg;
      logic                      diff_neg;
      logic                      a_dyn;
      logic                      b_dyn;
      logic                      degen;
      logic [2:0][UNIT_BITS-1:0] u;
      logic [46:0]               dmag;
      logic [33:0]               smag;
   } m1_type;

   typedef struct packed {
      logic [2:0]                d_neg;
      logic                      a_dyn;
      logic                      b_dyn;
      logic                      degen;
      logic [2:0][UNIT_BITS-1:0] u;
      logic                      fneg;
      logic [33:0]               fmag;
   } m2_type;

   typedef struct packed {
      logic [2:0]       neg;
      logic             a_dyn;
      logic             b_dyn;
      logic             degen;
      logic [2:0][34:0] comp;
   } m3_type;

   function automatic sq_type sqrt_step(sq_type x);
      sq_type      y;
      logic [34:0] rem_sh;
      logic [34:0] trial;
      y      = x;
      rem_sh = {x.rem[32:0], x.n[63:62]};
      trial  = {1'b0, x.root, 2'b01};
      y.n    = {x.n[61:0], 2'b00};
      if (rem_sh >= trial) begin
         y.rem  = rem_sh - trial;
         y.root = {x.root[30:0], 1'b1};
      end else begin
         y.rem  = rem_sh;
         y.root = {x.root[30:0], 1'b0};
      end
      return y;
   endfunction

   function automatic dv_type div_step(dv_type x, logic unit_on);
      dv_type      y;
      logic [32:0] len_w;
      logic [32:0] rem_sh;
      logic [32:0] u_sh;
      y       = x;
      len_w   = {1'b0, x.len};
      rem_sh  = {x.r_rem, x.r_low[RATIO_BITS-1]};
      y.r_low = {x.r_low[RATIO_BITS-2:0], 1'b0};
      if (rem_sh >= len_w) begin
         y.r_rem = 32'(rem_sh - len_w);
         y.r_q   = {x.r_q[RATIO_BITS-2:0], 1'b1};
      end else begin
         y.r_rem = rem_sh[31:0];
         y.r_q   = {x.r_q[RATIO_BITS-2:0], 1'b0};
      end
      if (unit_on) begin
         for (int i = 0; i < 3; i++) begin
            u_sh       = {x.u_rem[i], x.u_low[i][UNIT_BITS-1]};
            y.u_low[i] = {x.u_low[i][UNIT_BITS-2:0], 1'b0};
            if (u_sh >= len_w) begin
               y.u_rem[i] = 32'(u_sh - len_w);
               y.u_q[i]   = {x.u_q[i][UNIT_BITS-2:0], 1'b1};
            end else begin
               y.u_rem[i] = u_sh[31:0];
               y.u_q[i]   = {x.u_q[i][UNIT_BITS-2:0], 1'b0};
            end
         end
      end
      return y;
   endfunction

   logic [PIPE_DEPTH-1:0] vld_ff, vld_in;
   logic                  adv;

   sq_type  sq_head;
   sq_type  sq_ff [SQRT_STEPS];
   sq_type  sq_in [SQRT_STEPS];
   dv_type  e_ff, e_in;
   dv_type  dv_ff [RATIO_BITS];
   dv_type  dv_in [RATIO_BITS];
   m1_type  m1_ff, m1_in;
   m2_type  m2_ff, m2_in;
   m3_type  m3_ff, m3_in;
   rsp_type out_ff, out_in;

   logic [32:0]           diff;
   logic [RATIO_BITS-1:0] ratio;
   logic [62:0]           prod_d;
   logic [49:0]           prod_s;
   logic [48:0]           spr_s, damp_s, total;
   logic [47:0]           tmag;
   logic [64:0]           prod_u [3];
   logic [30:0]           comp_c [3];
   logic signed [31:0]    fa [3];

   assign adv       = !vld_ff[PIPE_DEPTH-1] || out_ready;
   assign in_pop    = adv && in_valid;
   assign vld_in    = {vld_ff[PIPE_DEPTH-2:0], in_valid};
   assign out_valid = vld_ff[PIPE_DEPTH-1];
   assign out_item  = out_ff;

   always_comb begin
      sq_head      = '0;
      sq_head.side = in_item.side;
      sq_head.n    = in_item.sq_sum;
      sq_in[0]     = sqrt_step(sq_head);
      for (int j = 1; j < SQRT_STEPS; j++) begin
         sq_in[j] = sqrt_step(sq_ff[j-1]);
      end
   end

   always_comb begin
      e_in          = '0;
      e_in.d_neg    = sq_ff[SQRT_STEPS-1].side.d_neg;
      e_in.dot_neg  = sq_ff[SQRT_STEPS-1].side.dot_neg;
      e_in.k        = sq_ff[SQRT_STEPS-1].side.k;
      e_in.c        = sq_ff[SQRT_STEPS-1].side.c;
      e_in.a_dyn    = sq_ff[SQRT_STEPS-1].side.a_dyn;
      e_in.b_dyn    = sq_ff[SQRT_STEPS-1].side.b_dyn;
      e_in.degen    = sq_ff[SQRT_STEPS-1].side.degen;
      e_in.len      = sq_ff[SQRT_STEPS-1].root;
      diff          = {1'b0, e_in.len} - {2'b00, sq_ff[SQRT_STEPS-1].side.rest};
      e_in.diff_neg = diff[32];
      e_in.diff_mag = diff[32] ? -diff : diff;
      e_in.sat      = {14'b0, sq_ff[SQRT_STEPS-1].side.dot_mag} >= {e_in.len, 30'b0};
      e_in.r_rem    = {14'b0, sq_ff[SQRT_STEPS-1].side.dot_mag[47:30]};
      e_in.r_low    = {sq_ff[SQRT_STEPS-1].side.dot_mag[29:0], 16'b0};
      for (int i = 0; i < 3; i++) begin
         e_in.u_rem[i] = {1'b0, sq_ff[SQRT_STEPS-1].side.d_mag[i][31:1]};
         e_in.u_low[i] = {sq_ff[SQRT_STEPS-1].side.d_mag[i][0], 30'b0};
      end
   end

   always_comb begin
      dv_in[0] = div_step(e_ff, 1'b1);
      for (int j = 1; j < RATIO_BITS; j++) begin
         dv_in[j] = div_step(dv_ff[j-1], j < UNIT_BITS);
      end
   end

   always_comb begin
      ratio          = dv_ff[RATIO_BITS-1].sat ? RATIO_MAX : dv_ff[RATIO_BITS-1].r_q;
      prod_d         = {17'b0, ratio} * {46'b0, dv_ff[RATIO_BITS-1].c};
      prod_s         = {17'b0, dv_ff[RATIO_BITS-1].diff_mag} * {33'b0, dv_ff[RATIO_BITS-1].k};
      m1_in.d_neg    = dv_ff[RATIO_BITS-1].d_neg;
      m1_in.dot_neg  = dv_ff[RATIO_BITS-1].dot_neg;
      m1_in.diff_neg = dv_ff[RATIO_BITS-1].diff_neg;
      m1_in.a_dyn    = dv_ff[RATIO_BITS-1].a_dyn;
      m1_in.b_dyn    = dv_ff[RATIO_BITS-1].b_dyn;
      m1_in.degen    = dv_ff[RATIO_BITS-1].degen;
      m1_in.u        = dv_ff[RATIO_BITS-1].u_q;
      m1_in.dmag     = prod_d[62:16];
      m1_in.smag     = prod_s[49:16];
   end

   always_comb begin
      spr_s       = m1_ff.diff_neg ? -{15'b0, m1_ff.smag} : {15'b0, m1_ff.smag};
      damp_s      = m1_ff.dot_neg ? -{2'b00, m1_ff.dmag} : {2'b00, m1_ff.dmag};
      total       = spr_s + damp_s;
      tmag        = total[48] ? 48'(-total) : total[47:0];
      m2_in.d_neg = m1_ff.d_neg;
      m2_in.a_dyn = m1_ff.a_dyn;
      m2_in.b_dyn = m1_ff.b_dyn;
      m2_in.degen = m1_ff.degen;
      m2_in.u     = m1_ff.u;
      m2_in.fneg  = !total[48] && (total != '0);
      m2_in.fmag  = (tmag > {14'b0, FORCE_MAX}) ? FORCE_MAX : tmag[33:0];
   end

   always_comb begin
      m3_in.a_dyn = m2_ff.a_dyn;
      m3_in.b_dyn = m2_ff.b_dyn;
      m3_in.degen = m2_ff.degen;
      for (int i = 0; i < 3; i++) begin
         prod_u[i]     = {31'b0, m2_ff.fmag} * {34'b0, m2_ff.u[i]};
         m3_in.comp[i] = prod_u[i][64:30];
         m3_in.neg[i]  = m2_ff.fneg ^ m2_ff.d_neg[i];
      end
   end

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         comp_c[i] = (m3_ff.comp[i] > {4'b0, OUT_MAX}) ? OUT_MAX : m3_ff.comp[i][30:0];
         fa[i]     = m3_ff.neg[i] ? -{1'b0, comp_c[i]} : {1'b0, comp_c[i]};
         if (m3_ff.degen) begin
            fa[i] = '0;
         end
      end
      out_in.force_a_x  = fa[0];
      out_in.force_a_y  = fa[1];
      out_in.force_a_z  = fa[2];
      out_in.force_b_x  = -fa[0];
      out_in.force_b_y  = -fa[1];
      out_in.force_b_z  = -fa[2];
      out_in.apply_a    = m3_ff.a_dyn && !m3_ff.degen;
      out_in.apply_b    = m3_ff.b_dyn && !m3_ff.degen;
      out_in.degenerate = m3_ff.degen;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (adv) begin
         vld_ff <= vld_in;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         for (int j = 0; j < SQRT_STEPS; j++) begin
            sq_ff[j] <= sq_in[j];
         end
         e_ff <= e_in;
         for (int j = 0; j < RATIO_BITS; j++) begin
            dv_ff[j] <= dv_in[j];
         end
         m1_ff  <= m1_in;
         m2_ff  <= m2_in;
         m3_ff  <= m3_in;
         out_ff <= out_in;
      end
   end

endmodule
